// ===== rtl/positional_list_engine_assert.svh =====
// Assertion macros used by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLE_ASSERT(label, clk, rst_n, prop, msg)
`define PLE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/ple_pkg.sv =====
// Shared constants and codes of the positional list engine.
package ple_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);

	localparam int CMD_W  = 3;
	localparam int POS_W  = 8;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCNT_W = 6;
	localparam int CMP_W  = POS_W + 1;

	localparam logic [CMD_W-1:0] CMD_INS_FIRST = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_LAST  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

endpackage

// ===== rtl/ple_cmd_if.sv =====
// Command channel interface of the positional list engine.
interface ple_cmd_if;
	import ple_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, command, position, value, input ready);
	modport sink (input valid, command, position, value, output ready);
endinterface

// ===== rtl/ple_res_if.sv =====
// Result channel interface of the positional list engine.
interface ple_res_if;
	import ple_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic [OCNT_W-1:0]       element_count;
	logic signed [VAL_W-1:0] element_value;
	logic                    last_of_run;

	modport source (output valid, status, element_count, element_value, last_of_run,
		input ready);
	modport sink (input valid, status, element_count, element_value, last_of_run,
		output ready);
endinterface

// ===== rtl/ple_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: sequencer, element RAM and result register.
// Takes one command at a time; ready is high only while no command is in progress.
// Insert at slot k shifts the elements from slot k up by one, last first; delete shifts those after slot k down.
// Error results and the empty dump go through the S_RESP state to the result register.
// Dump: each element is read in S_DUMP_RD and handed over in S_DUMP_WR, which waits while the result is held.
// Reset clears the element count and all control state; the element RAM is not cleared.
`include "positional_list_engine_assert.svh"

module positional_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	ple_cmd_if.sink    cmd,
	ple_res_if.source  rsp
);
	import ple_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_INS     = 6'b000010,
		S_DEL     = 6'b000100,
		S_DUMP_RD = 6'b001000,
		S_DUMP_WR = 6'b010000,
		S_RESP    = 6'b100000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   mv_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [VAL_W-1:0]   value_q;
	logic [STAT_W-1:0]  status_q;
	logic               wr_s1;
	logic [ADDR_W-1:0]  waddr_s1;

	logic               rsp_valid_q;
	logic [STAT_W-1:0]  rsp_status_q;
	logic [OCNT_W-1:0]  rsp_count_q;
	logic [VAL_W-1:0]   rsp_value_q;
	logic               rsp_last_q;

	logic               acc;
	logic               out_free;
	logic               rsp_load;
	logic               full;
	logic               empty;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	state_t             dec_state;
	logic [STAT_W-1:0]  dec_status;
	logic [CNT_W-1:0]   dec_idx;
	logic [CNT_W-1:0]   dec_mv;
	logic [ADDR_W-1:0]  dec_ptr;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [VAL_W-1:0]   ram_rdata;

	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp_load  = out_free && ((state_q == S_RESP) || (state_q == S_DUMP_WR));

	// decode and range-check the command
	always_comb begin
		pos_x      = {1'b0, cmd.position};
		cnt_x      = CMP_W'(count_q);
		full       = (count_q == CNT_W'(CAPACITY));
		empty      = (count_q == '0);
		dec_state  = S_RESP;
		dec_status = ST_INVALID;
		dec_idx    = '0;
		unique case (cmd.command)
			CMD_INS_FIRST: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_state  = S_INS;
					dec_status = ST_OK;
				end
			end
			CMD_INS_LAST: begin
				dec_idx = count_q;
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_state  = S_INS;
					dec_status = ST_OK;
				end
			end
			CMD_INS_AT: begin
				dec_idx = CNT_W'(pos_x - CMP_W'(1));
				if ((pos_x == '0) || (pos_x > cnt_x + CMP_W'(1))) begin
					dec_status = ST_INVALID;
				end else if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_state  = S_INS;
					dec_status = ST_OK;
				end
			end
			CMD_DEL_FIRST: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state  = S_DEL;
					dec_status = ST_OK;
				end
			end
			CMD_DEL_LAST: begin
				dec_idx = count_q - CNT_W'(1);
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state  = S_DEL;
					dec_status = ST_OK;
				end
			end
			CMD_DEL_AT: begin
				dec_idx = CNT_W'(pos_x - CMP_W'(1));
				if ((pos_x == '0) || (pos_x > cnt_x)) begin
					dec_status = ST_INVALID;
				end else begin
					dec_state  = S_DEL;
					dec_status = ST_OK;
				end
			end
			CMD_DUMP: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state  = S_DUMP_RD;
					dec_status = ST_OK;
				end
			end
			default: begin
				dec_status = ST_INVALID;
			end
		endcase

		unique case (dec_state)
			S_INS: begin
				dec_mv  = count_q - dec_idx;
				dec_ptr = ADDR_W'(count_q - CNT_W'(1));
			end
			S_DEL: begin
				dec_mv  = count_q - CNT_W'(1) - dec_idx;
				dec_ptr = ADDR_W'(dec_idx + CNT_W'(1));
			end
			default: begin
				dec_mv  = count_q;
				dec_ptr = '0;
			end
		endcase
	end

	// element RAM access: at most one read and one write per cycle
	always_comb begin
		ram_re    = (((state_q == S_INS) || (state_q == S_DEL)) && (mv_q != '0)) ||
			(state_q == S_DUMP_RD);
		ram_we    = wr_s1 || ((state_q == S_INS) && (mv_q == '0));
		ram_waddr = wr_s1 ? waddr_s1 : idx_q;
		ram_wdata = wr_s1 ? ram_rdata : value_q;
	end

	ple_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mv_q        <= '0;
			ptr_q       <= '0;
			wr_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wr_s1 <= ((state_q == S_INS) || (state_q == S_DEL)) && (mv_q != '0);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= dec_state;
						mv_q    <= dec_mv;
						ptr_q   <= dec_ptr;
					end
				end
				S_INS: begin
					if (mv_q != '0) begin
						mv_q  <= mv_q - CNT_W'(1);
						ptr_q <= ptr_q - ADDR_W'(1);
					end else if (!wr_s1) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_DEL: begin
					if (mv_q != '0) begin
						mv_q  <= mv_q - CNT_W'(1);
						ptr_q <= ptr_q + ADDR_W'(1);
					end else if (!wr_s1) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_WR;
				end
				S_DUMP_WR: begin
					if (out_free) begin
						mv_q    <= mv_q - CNT_W'(1);
						ptr_q   <= ptr_q + ADDR_W'(1);
						state_q <= (mv_q == CNT_W'(1)) ? S_IDLE : S_DUMP_RD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= dec_status;
			idx_q    <= ADDR_W'(dec_idx);
			value_q  <= cmd.value;
		end
		if (state_q == S_INS) begin
			waddr_s1 <= ptr_q + ADDR_W'(1);
		end else begin
			waddr_s1 <= ptr_q - ADDR_W'(1);
		end
		if (rsp_load) begin
			rsp_count_q <= OCNT_W'(count_q);
			if (state_q == S_DUMP_WR) begin
				rsp_status_q <= ST_OK;
				rsp_value_q  <= ram_rdata;
				rsp_last_q   <= (mv_q == CNT_W'(1));
			end else begin
				rsp_status_q <= status_q;
				rsp_value_q  <= '0;
				rsp_last_q   <= 1'b1;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.element_count = rsp_count_q;
	assign rsp.element_value = rsp_value_q;
	assign rsp.last_of_run   = rsp_last_q;

	`PLE_ASSERT_NEVER(a_count_bound, clk, arst_n,
		count_q > CNT_W'(CAPACITY), "count exceeds capacity")
	`PLE_ASSERT(a_count_step, clk, arst_n,
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CNT_W'(1)) ||
		(count_q == $past(count_q) - CNT_W'(1))),
		"count moved by more than one")
	`PLE_ASSERT_NEVER(a_idle_no_write, clk, arst_n,
		(state_q == S_IDLE) && ram_we, "element RAM written while idle")
	`PLE_ASSERT(a_value_only_ok, clk, arst_n,
		(rsp.valid && ((rsp.element_value != '0) || !rsp.last_of_run)) |->
		(rsp.status == ST_OK), "dump data carried with error status")
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the positional list engine: directed table, then random commands.
`timescale 1ns / 1ps

module tb;
	import ple_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;
	localparam int RANDOM_ITEMS = 146;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic [OCNT_W-1:0]       count;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} list_result_t;

	typedef struct {
		logic [CMD_W-1:0]        command;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		bit                      typed;
		logic [STAT_W-1:0]       t_status;
		logic [OCNT_W-1:0]       t_count;
	} list_cmd_t;

	typedef enum {PH_MIXED, PH_FILL, PH_DRAIN} mix_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	ple_cmd_if cmd_ch();
	ple_res_if rsp_ch();

	positional_list_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic signed [VAL_W-1:0] list_mem [CAPACITY];
	int list_len = 0;
	list_result_t expected_results [$];
	list_cmd_t directed_rows [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit hold_off_req = 1'b0;

	mix_phase_t phase = PH_MIXED;
	int phase_left = 10;
	int bound_hits = 0;
	bit fill_next = 1'b1;

	task automatic add_row(input logic [CMD_W-1:0] c, input int p,
			input logic signed [VAL_W-1:0] v, input bit typed,
			input logic [STAT_W-1:0] st, input int cnt);
		list_cmd_t row;
		row.command = c;
		row.position = p[POS_W-1:0];
		row.value = v;
		row.typed = typed;
		row.t_status = st;
		row.t_count = cnt[OCNT_W-1:0];
		directed_rows.push_back(row);
	endtask

	task automatic apply_command(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
			input logic signed [VAL_W-1:0] v, input bit keep);
		logic [STAT_W-1:0] st;
		int ins_idx;
		int del_idx;
		int i;
		st = ST_OK;
		ins_idx = -1;
		del_idx = -1;
		case (c)
			CMD_INS_FIRST: ins_idx = 0;
			CMD_INS_LAST: ins_idx = list_len;
			CMD_INS_AT: begin
				if (p < 1 || p > list_len + 1)
					st = ST_INVALID;
				else
					ins_idx = p - 1;
			end
			CMD_DEL_FIRST: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else
					del_idx = 0;
			end
			CMD_DEL_LAST: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else
					del_idx = list_len - 1;
			end
			CMD_DEL_AT: begin
				if (p < 1 || p > list_len)
					st = ST_INVALID;
				else
					del_idx = p - 1;
			end
			CMD_DUMP: begin
				if (list_len == 0) begin
					if (keep)
						expected_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
				end else if (keep) begin
					for (i = 0; i < list_len; i++)
						expected_results.push_back('{ST_OK, list_len[OCNT_W-1:0],
							list_mem[i], (i + 1 == list_len)});
				end
				return;
			end
			default: st = ST_INVALID;
		endcase
		if (ins_idx >= 0) begin
			if (list_len >= CAPACITY) begin
				st = ST_FULL;
			end else begin
				for (i = list_len; i > ins_idx; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[ins_idx] = v;
				list_len++;
			end
		end
		if (del_idx >= 0) begin
			for (i = del_idx; i + 1 < list_len; i++)
				list_mem[i] = list_mem[i + 1];
			list_len--;
		end
		if (keep)
			expected_results.push_back('{st, list_len[OCNT_W-1:0], '0, 1'b1});
	endtask

	task automatic next_random_command(output list_cmd_t item);
		int roll;
		int kind;
		case (phase)
			PH_MIXED: begin
				if (phase_left == 0) begin
					phase = fill_next ? PH_FILL : PH_DRAIN;
					fill_next = !fill_next;
					bound_hits = 0;
				end else begin
					phase_left--;
				end
			end
			PH_FILL: begin
				if (list_len == CAPACITY)
					bound_hits++;
				if (bound_hits > 4) begin
					phase = PH_MIXED;
					phase_left = $urandom_range(10, 25);
				end
			end
			default: begin
				if (list_len == 0)
					bound_hits++;
				if (bound_hits > 3) begin
					phase = PH_MIXED;
					phase_left = $urandom_range(10, 25);
				end
			end
		endcase
		roll = $urandom_range(0, 99);
		case (phase)
			PH_FILL: kind = (roll < 85) ? 0 : (roll < 93) ? 1 : 2;
			PH_DRAIN: kind = (roll < 85) ? 1 : (roll < 94) ? 0 : 2;
			default: kind = (roll < 40) ? 0 : (roll < 80) ? 1 : (roll < 94) ? 2 : 3;
		endcase
		case (kind)
			0: begin
				case ($urandom_range(0, 2))
					0: item.command = CMD_INS_FIRST;
					1: item.command = CMD_INS_LAST;
					default: item.command = CMD_INS_AT;
				endcase
			end
			1: begin
				case ($urandom_range(0, 2))
					0: item.command = CMD_DEL_FIRST;
					1: item.command = CMD_DEL_LAST;
					default: item.command = CMD_DEL_AT;
				endcase
			end
			2: item.command = CMD_DUMP;
			default: item.command = CMD_RESERVED;
		endcase
		case (item.command)
			CMD_INS_AT: begin
				if ($urandom_range(0, 4) != 0)
					item.position = $urandom_range(1, list_len + 1);
				else
					item.position = $urandom_range(0, 255);
			end
			CMD_DEL_AT: begin
				if (list_len > 0 && $urandom_range(0, 4) != 0)
					item.position = $urandom_range(1, list_len);
				else
					item.position = $urandom_range(0, 255);
			end
			default: item.position = $urandom_range(0, 255);
		endcase
		item.value = $urandom;
		item.typed = 1'b0;
		item.t_status = ST_OK;
		item.t_count = '0;
	endtask

	task automatic note_mismatch(input string what, input list_result_t want,
			input list_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: exp st=%0d cnt=%0d val=%0d last=%0b got st=%0d cnt=%0d val=%0d last=%0b",
				what, want.status, want.count, want.value, want.last,
				got.status, got.count, got.value, got.last);
	endtask

	initial begin : drive_commands
		list_cmd_t item;
		int n;
		int total;
		int burst_left;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_INS_FIRST;
		cmd_ch.position = '0;
		cmd_ch.value = '0;
		arst_n = 1'b0;

		add_row(CMD_DUMP,      0, 0, 1, ST_EMPTY,   0);
		add_row(CMD_DEL_FIRST, 0, 0, 1, ST_EMPTY,   0);
		add_row(CMD_DEL_LAST,  0, 0, 1, ST_EMPTY,   0);
		add_row(CMD_DEL_AT,    1, 0, 1, ST_INVALID, 0);
		add_row(CMD_INS_AT,    0, 0, 1, ST_INVALID, 0);
		add_row(CMD_INS_AT,    2, 0, 1, ST_INVALID, 0);
		add_row(CMD_RESERVED,  0, 0, 1, ST_INVALID, 0);
		add_row(CMD_INS_FIRST, 0, 32'sh7FFFFFFF, 1, ST_OK, 1);
		add_row(CMD_INS_LAST,  255, 32'sh80000000, 1, ST_OK, 2);
		add_row(CMD_INS_AT,    2, 0, 0, ST_OK, 0);
		add_row(CMD_INS_AT,    4, 32'shFFFFFFFF, 0, ST_OK, 0);
		add_row(CMD_INS_AT,    255, 0, 1, ST_INVALID, 4);
		add_row(CMD_DUMP,      0, 0, 0, ST_OK, 0);
		add_row(CMD_DEL_AT,    5, 0, 1, ST_INVALID, 4);
		add_row(CMD_DEL_AT,    0, 0, 1, ST_INVALID, 4);
		add_row(CMD_DEL_AT,    4, 0, 0, ST_OK, 0);
		add_row(CMD_DEL_AT,    2, 0, 0, ST_OK, 0);
		add_row(CMD_DEL_FIRST, 0, 0, 0, ST_OK, 0);
		add_row(CMD_DUMP,      0, 0, 0, ST_OK, 0);
		add_row(CMD_DEL_LAST,  0, 0, 0, ST_OK, 0);
		add_row(CMD_DUMP,      0, 0, 1, ST_EMPTY, 0);
		add_row(CMD_INS_AT,    1, 32'sh55555555, 0, ST_OK, 0);
		add_row(CMD_INS_AT,    1, 32'shAAAAAAAA, 0, ST_OK, 0);
		add_row(CMD_DUMP,      0, 0, 0, ST_OK, 0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		total = directed_rows.size() + RANDOM_ITEMS;
		burst_left = 0;
		for (n = 0; n < total; n++) begin
			if (n < directed_rows.size())
				item = directed_rows[n];
			else
				next_random_command(item);
			if (n == directed_rows.size() + 50)
				hold_off_req = 1'b1;
			if (burst_left == 0) begin
				cmd_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
					: $urandom_range(1, 6);
			end
			cmd_ch.valid <= 1'b1;
			cmd_ch.command <= item.command;
			cmd_ch.position <= item.position;
			cmd_ch.value <= item.value;
			@(posedge clk);
			while (!cmd_ch.ready)
				@(posedge clk);
			apply_command(item.command, item.position, item.value, !item.typed);
			if (item.typed)
				expected_results.push_back('{item.t_status, item.t_count, '0, 1'b1});
			burst_left--;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : drive_ready
		int mode;
		int span;
		int tick;
		bit hold_off_done;
		rsp_ch.ready = 1'b0;
		hold_off_done = 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 60);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (hold_off_req && !hold_off_done) begin
					rsp_ch.ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_done = 1'b1;
				end else begin
					case (mode)
						0: rsp_ch.ready <= 1'b1;
						1: rsp_ch.ready <= $urandom_range(0, 1);
						2: rsp_ch.ready <= (tick % 4) != 0;
						default: rsp_ch.ready <= ($urandom_range(0, 9) < 2);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t want;
		list_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.status, rsp_ch.element_count, rsp_ch.element_value,
				rsp_ch.last_of_run};
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.count !== want.count ||
						got.value !== want.value || got.last !== want.last)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_cmd_if.sv
rtl/ple_res_if.sv
rtl/ple_ram.sv
rtl/positional_list_engine.sv
tb/tb.sv
